// ===== src/brdp_pkg.sv =====
// brdp_pkg: shared types and constants of the byte range decimal parser
// no dependencies; used by the interfaces, the top level and the checker
package brdp_pkg;

    localparam int unsigned MAX_VALUE_DEF = 255;
    localparam int unsigned CH_W          = 8;
    localparam int unsigned VALUE_W       = 8;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_DIGIT = 2'd1,
        PH_TRAIL = 2'd2,
        PH_ERR   = 2'd3
    } t_phase;

endpackage

// ===== src/brdp_if.sv =====
// brdp_if: valid/ready channel interfaces for characters and results
// depends on brdp_pkg for field widths
interface brdp_in_if;
    logic                        valid;
    logic                        ready;
    logic [brdp_pkg::CH_W-1:0]   ch;
    logic                        is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface brdp_out_if;
    logic                         valid;
    logic                         ready;
    logic [brdp_pkg::VALUE_W-1:0] value;
    logic                         error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== src/byte_range_decimal_parser.sv =====
// byte_range_decimal_parser: top level, decimal text field to byte value
// depends on brdp_pkg and the channel interfaces in brdp_if.sv
//
// The block takes one character per transfer on i_in and a terminator transfer
// (is_end high) that closes the field. Leading spaces and tabs are skipped, an
// optional '+' is taken, a '-' is an error; digits then accumulate and the
// field is in error once the value passes MAX_VALUE. Only spaces and tabs may
// follow the digits. On the terminator one result transfer leaves on o_res
// with the value (0 when error is set, low 8 bits when MAX_VALUE is above 255)
// and the error flag, and the parser returns to its start state. Throughput is
// one character per cycle while no terminator stalls: each transfer lands in an
// input register, and the next cycle character compares plus a multiply-by-ten
// add update the phase and accumulator. A terminator then loads the result
// register, waiting in the input register while an earlier result is untaken.
// The result register frees the input side, so characters keep flowing while a
// result waits; only a second terminator stalls behind an untaken result.
module byte_range_decimal_parser #(
    parameter int unsigned MAX_VALUE = brdp_pkg::MAX_VALUE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    brdp_in_if.sink           i_in,
    brdp_out_if.source        o_res
);

    // accumulator holds 0..MAX_VALUE; one more digit needs four more bits
    localparam int unsigned ACC_W = $clog2(MAX_VALUE + 1);
    localparam int unsigned NXT_W = ACC_W + 4;
    localparam int unsigned EXT_W = ACC_W + brdp_pkg::VALUE_W;

    // input register
    logic                          r_in_valid;
    logic [brdp_pkg::CH_W-1:0]     r_ch;
    logic                          r_is_end;

    // parser state
    brdp_pkg::t_phase              r_phase, n_phase;
    logic [ACC_W-1:0]              r_acc, n_acc;

    // result register
    logic                          r_out_valid;
    logic [brdp_pkg::VALUE_W-1:0]  r_value, n_value;
    logic                          r_error, n_error;

    logic                          out_free;
    logic                          s1_go;
    logic                          in_take;
    logic                          is_blank;
    logic                          is_digit;
    logic [3:0]                    dig;
    logic [NXT_W-1:0]              acc_next;
    logic                          overflow;
    logic [EXT_W-1:0]              acc_ext;

    // result slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || o_res.ready;
    // a character always moves on; a terminator needs the result slot
    assign s1_go    = r_in_valid && (!r_is_end || out_free);
    assign i_in.ready = !r_in_valid || s1_go;
    assign in_take  = i_in.valid && i_in.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.value = r_value;
    assign o_res.error = r_error;

    // character classes
    assign is_blank = (r_ch == brdp_pkg::CH_SPACE) || (r_ch == brdp_pkg::CH_TAB);
    assign is_digit = (r_ch >= brdp_pkg::CH_ZERO) && (r_ch <= brdp_pkg::CH_NINE);
    assign dig      = r_ch[3:0];  // '0'..'9' carry the digit in the low nibble

    // acc * 10 + digit as two shifts and an add
    assign acc_next = (NXT_W'(r_acc) << 3) + (NXT_W'(r_acc) << 1) + NXT_W'(dig);
    assign overflow = acc_next > NXT_W'(MAX_VALUE);

    // output value is the low byte of the accumulator
    assign acc_ext  = {{brdp_pkg::VALUE_W{1'b0}}, r_acc};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_value = r_value;
        n_error = r_error;
        if (r_is_end) begin
            // emit and restart
            n_error = (r_phase == brdp_pkg::PH_ERR);
            n_value = n_error ? '0 : acc_ext[brdp_pkg::VALUE_W-1:0];
            n_phase = brdp_pkg::PH_LEAD;
            n_acc   = '0;
        end else begin
            case (r_phase)
                brdp_pkg::PH_LEAD: begin
                    if (is_blank) begin
                        n_phase = brdp_pkg::PH_LEAD;
                    end else if (r_ch == brdp_pkg::CH_PLUS) begin
                        n_phase = brdp_pkg::PH_DIGIT;
                    end else if (is_digit) begin
                        n_phase = overflow ? brdp_pkg::PH_ERR : brdp_pkg::PH_DIGIT;
                        if (!overflow) begin
                            n_acc = acc_next[ACC_W-1:0];
                        end
                    end else begin
                        // minus sign or any stray character
                        n_phase = brdp_pkg::PH_ERR;
                    end
                end
                brdp_pkg::PH_DIGIT: begin
                    if (is_digit) begin
                        n_phase = overflow ? brdp_pkg::PH_ERR : brdp_pkg::PH_DIGIT;
                        if (!overflow) begin
                            n_acc = acc_next[ACC_W-1:0];
                        end
                    end else if (is_blank) begin
                        n_phase = brdp_pkg::PH_TRAIL;
                    end else begin
                        n_phase = brdp_pkg::PH_ERR;
                    end
                end
                brdp_pkg::PH_TRAIL: begin
                    if (!is_blank) begin
                        n_phase = brdp_pkg::PH_ERR;
                    end
                end
                default: begin
                    // error is sticky until the terminator
                    n_phase = brdp_pkg::PH_ERR;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch     <= i_in.ch;
            r_is_end <= i_in.is_end;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= brdp_pkg::PH_LEAD;
            r_acc   <= '0;
        end else if (s1_go) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_is_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_is_end) begin
            r_value <= n_value;
            r_error <= n_error;
        end
    end

endmodule

// ===== src/brdp_checker.sv =====
// brdp_checker: port-level assertions for byte_range_decimal_parser
// depends on brdp_pkg; bound to the top level at the end of this file
module brdp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_is_end,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [brdp_pkg::VALUE_W-1:0] i_out_value,
    input logic                         i_out_error
);

    // terminators taken whose result has not been transferred yet
    logic [1:0] r_pend;
    logic       term_in;
    logic       res_out;

    assign term_in = i_in_valid && i_in_ready && i_in_is_end;
    assign res_out = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(term_in) - 2'(res_out);
        end
    end

    // an errored result always reports value zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_value == '0)
        else $error("error result with nonzero value");

    // no result without a terminator in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without a terminator");

    // at most the input register and the result register hold terminators
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many terminators in flight");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_error))
        else $error("stalled result changed");

endmodule

bind byte_range_decimal_parser brdp_checker u_brdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_is_end (i_in.is_end),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.value),
    .i_out_error (o_res.error)
);
